/* rtl/core/five_point_grid_smoother_assert.svh */
// concurrent assertion macros for the grid smoother
`ifndef FIVE_POINT_GRID_SMOOTHER_ASSERT_SVH
`define FIVE_POINT_GRID_SMOOTHER_ASSERT_SVH

`ifndef SYNTH

// condition must hold in the same cycle
`define FPGS_ASSERT_COMB(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);

// condition must hold in the following cycle
`define FPGS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);

`else

`define FPGS_ASSERT_COMB(lbl, ant, con, msg)
`define FPGS_ASSERT_NEXT(lbl, ant, con, msg)

`endif

`endif

/* rtl/core/fpgs_pkg.sv */
`timescale 1ns / 1ps

package fpgs_pkg;

    // grid geometry
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    // field and register widths
    localparam int PIX_W  = 16;
    localparam int ROW_W  = 7;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = 8;
    localparam int CIDX_W = 2;

    // saturation level of the five-point mode
    localparam logic [PIX_W-1:0] SAT_LIMIT = PIX_W'(255);

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_GRID_HEIGHT = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_SMOOTH_MODE = CIDX_W'(2);

    // register reset values
    localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = DIM_W'(60);
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = DIM_W'(50);

    // item kinds and modes
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;
    localparam logic MODE_SUM5  = 1'b0;

    // control of one cell on its way to the output
    typedef struct packed {
        logic             res;
        logic             sel;
        logic             top_en;
        logic             left_en;
        logic             right_en;
        logic             frame_end;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] bot;
    } t_cell_ctrl;

    // zero counts as one, above the maximum saturates
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (v > maxv) begin
            d = maxv;
        end else begin
            d = v;
        end
        return d;
    endfunction

endpackage

/* rtl/core/five_point_grid_smoother.sv */
`timescale 1ns / 1ps
// Five-point smoothing of a raster-order grid.
// Input channel (i_valid / o_stall): one item per transfer. A pixel item
// (i_kind = 0) carries the next cell of the grid in raster order; a drain
// item (i_kind = 1) flushes one cell of the last row after the grid ends.
// Output channel (o_valid / i_stall): one smoothed cell per transfer, with
// its row, column and a flag on the last cell of the grid. Results lag the
// input by one row; row 0 pixels give no result, drain items one each.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): width, height and
// mode, which the user must write only while idle; the block does not enforce it.
// Throughput: one item per cycle. The two line memories are read at
// columns c and c+1 when an item is taken, and a pixel item writes the
// upper one at c, so nothing limits the rate but the handshakes.
// A taken item passes the memory read stage, then the output register,
// before its result is presented.
// Reset clears the counters, the drain flag, the registers to 60 x 50
// mode 0, and the valid bits of both line memories.
// A stall on the output holds the output register; the stage behind it
// keeps taking items until it holds a result too, then o_stall rises.
`include "five_point_grid_smoother_assert.svh"

module five_point_grid_smoother import fpgs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    // input items
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_kind,
    input  logic [PIX_W-1:0]  i_pixel,
    // results
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_smoothed,
    output logic [ROW_W-1:0]  o_out_row,
    output logic [COL_W-1:0]  o_out_col,
    output logic              o_frame_end
);

    // config registers
    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic             r_smooth_mode;

    // position state
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [COL_W-1:0] r_drain_col, n_drain_col;
    logic             r_draining, n_draining;
    logic             r_sel, n_sel;

    // line memories and their valid bits
    logic [PIX_W-1:0]     r_line0 [MAX_WIDTH];
    logic [PIX_W-1:0]     r_line1 [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_vld0;
    logic [MAX_WIDTH-1:0] r_vld1;
    logic [PIX_W-1:0]     r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;
    logic                 r_rv0_a, r_rv0_b, r_rv1_a, r_rv1_b;

    // read stage
    logic       r_s1_valid;
    t_cell_ctrl r_s1;
    t_cell_ctrl s0_ctrl;
    logic [PIX_W-1:0] r_prev_mid;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_smoothed;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic             r_out_frame_end;

    logic [DIM_W-1:0] w, h;
    logic             accept, s0_is_pix, s0_enter, wr_pix;
    logic [COL_W-1:0] s0_col, addr_a, addr_b;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             last_col, last_row;
    logic             out_free, s1_move, out_load;

    logic [PIX_W-1:0] m0_a, m0_b, m1_a, m1_b;
    logic [PIX_W-1:0] up_v, mid_c, mid_r, top_v, left_v, right_v;
    logic [PIX_W+1:0] nsum;
    logic [PIX_W+2:0] sum5;
    logic [PIX_W:0]   q0, q1;
    logic [PIX_W-1:0] cell_res;

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_smooth_mode <= MODE_SUM5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                CFG_SMOOTH_MODE: r_smooth_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective geometry
    assign w = eff_dim(r_grid_width, DIM_W'(MAX_WIDTH));
    assign h = eff_dim(r_grid_height, DIM_W'(MAX_HEIGHT));

    // handshake
    assign out_free = !r_out_valid || !i_stall;
    assign s1_move  = r_s1_valid && (!r_s1.res || out_free);
    assign out_load = s1_move && r_s1.res;
    assign o_stall  = r_s1_valid && !s1_move;
    assign accept   = i_valid && !o_stall;

    // items that do work: pixels outside the drain, drain items inside it
    assign s0_is_pix = (i_kind == KIND_PIXEL);
    assign s0_enter  = accept && (r_draining ? !s0_is_pix : s0_is_pix);
    assign wr_pix    = s0_enter && !r_draining;

    assign s0_col   = r_draining ? r_drain_col : r_in_col;
    assign col_inc  = {1'b0, s0_col} + DIM_W'(1);
    assign row_inc  = {1'b0, r_in_row} + DIM_W'(1);
    assign last_col = (col_inc >= w);
    assign last_row = (row_inc >= h);
    assign addr_a   = s0_col;
    assign addr_b   = s0_col + COL_W'(1);

    // cell control for the read stage
    always_comb begin
        s0_ctrl.sel       = r_sel;
        s0_ctrl.col       = s0_col;
        s0_ctrl.left_en   = (s0_col != '0);
        s0_ctrl.right_en  = !last_col;
        if (r_draining) begin
            s0_ctrl.res       = 1'b1;
            s0_ctrl.top_en    = (h > DIM_W'(1));
            s0_ctrl.frame_end = last_col;
            s0_ctrl.row       = ROW_W'(h - DIM_W'(1));
            s0_ctrl.bot       = '0;
        end else begin
            s0_ctrl.res       = (r_in_row != '0);
            s0_ctrl.top_en    = (r_in_row > ROW_W'(1));
            s0_ctrl.frame_end = 1'b0;
            s0_ctrl.row       = r_in_row - ROW_W'(1);
            s0_ctrl.bot       = i_pixel;
        end
    end

    // position update
    always_comb begin
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_drain_col = r_drain_col;
        n_draining  = r_draining;
        n_sel       = r_sel;
        if (s0_enter) begin
            if (r_draining) begin
                if (last_col) begin
                    n_draining  = 1'b0;
                    n_drain_col = '0;
                end else begin
                    n_drain_col = r_drain_col + COL_W'(1);
                end
            end else if (last_col) begin
                n_sel    = !r_sel;
                n_in_col = '0;
                if (last_row) begin
                    n_in_row    = '0;
                    n_draining  = 1'b1;
                    n_drain_col = '0;
                end else begin
                    n_in_row = r_in_row + ROW_W'(1);
                end
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_drain_col <= '0;
            r_draining  <= 1'b0;
            r_sel       <= 1'b0;
        end else begin
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_drain_col <= n_drain_col;
            r_draining  <= n_draining;
            r_sel       <= n_sel;
        end
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= '0;
            r_vld1 <= '0;
        end else if (wr_pix) begin
            if (r_sel) begin
                r_vld1[addr_a] <= 1'b1;
            end else begin
                r_vld0[addr_a] <= 1'b1;
            end
        end
    end

    // line memory 0: read at c and c+1, written at c when it is the upper line
    always_ff @(posedge i_clk) begin
        if (s0_enter) begin
            r_rd0_a <= r_line0[addr_a];
            r_rd0_b <= r_line0[addr_b];
            r_rv0_a <= r_vld0[addr_a];
            r_rv0_b <= r_vld0[addr_b];
        end
        if (wr_pix && !r_sel) begin
            r_line0[addr_a] <= i_pixel;
        end
    end

    // line memory 1
    always_ff @(posedge i_clk) begin
        if (s0_enter) begin
            r_rd1_a <= r_line1[addr_a];
            r_rd1_b <= r_line1[addr_b];
            r_rv1_a <= r_vld1[addr_a];
            r_rv1_b <= r_vld1[addr_b];
        end
        if (wr_pix && r_sel) begin
            r_line1[addr_a] <= i_pixel;
        end
    end

    // read stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s0_enter) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_enter) begin
            r_s1 <= s0_ctrl;
        end
    end

    // select upper and middle lines
    assign m0_a  = r_rv0_a ? r_rd0_a : '0;
    assign m0_b  = r_rv0_b ? r_rd0_b : '0;
    assign m1_a  = r_rv1_a ? r_rd1_a : '0;
    assign m1_b  = r_rv1_b ? r_rd1_b : '0;
    assign up_v  = r_s1.sel ? m1_a : m0_a;
    assign mid_c = r_s1.sel ? m0_a : m1_a;
    assign mid_r = r_s1.sel ? m0_b : m1_b;

    // neighbours outside the grid are zero
    assign top_v   = r_s1.top_en   ? up_v       : '0;
    assign left_v  = r_s1.left_en  ? r_prev_mid : '0;
    assign right_v = r_s1.right_en ? mid_r      : '0;

    // combine the stencil
    assign nsum = {2'b00, left_v} + {2'b00, right_v} + {2'b00, top_v}
                + {2'b00, r_s1.bot};
    assign sum5 = {1'b0, nsum} + {3'b000, mid_c};
    assign q0   = sum5[PIX_W+2:2];
    assign q1   = {1'b0, nsum[PIX_W+1:2]} + {1'b0, mid_c};

    always_comb begin
        if (r_smooth_mode == MODE_SUM5) begin
            cell_res = (q0 > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : q0[PIX_W-1:0];
        end else begin
            cell_res = q1[PIX_W:1];
        end
    end

    // centre of this cell is the left neighbour of the next one
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_prev_mid <= mid_c;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_smoothed  <= cell_res;
            r_out_row       <= r_s1.row;
            r_out_col       <= r_s1.col;
            r_out_frame_end <= r_s1.frame_end;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_smoothed  = r_out_smoothed;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_frame_end = r_out_frame_end;

    // checks
    `FPGS_ASSERT_COMB(a_stall_busy, o_stall, r_s1_valid, "stall without busy read stage")
    `FPGS_ASSERT_COMB(a_out_block, r_s1_valid && r_s1.res && r_out_valid && i_stall, o_stall, "result stage overrun")
    `FPGS_ASSERT_NEXT(a_col_step, wr_pix && !last_col, r_in_col == $past(r_in_col) + COL_W'(1), "column did not advance")
    `FPGS_ASSERT_NEXT(a_drain_done, s0_enter && r_draining && last_col, !r_draining && r_drain_col == '0, "drain did not end")

endmodule
